### hw/rtl/gds_pkg.sv
// ----------------------------------------------------------------------------
// gds_pkg
// Shared widths, unit codes and calendar helpers for the date subtractor.
// ----------------------------------------------------------------------------
package gds_pkg;

    // field widths
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int OP_W    = 3;
    localparam int CNT_W   = 10;
    localparam int UNIT_W  = 10;

    // year modulo 400 tracker width
    localparam int M400_W  = 9;

    // default clamp on the unit count
    localparam int MAX_COUNT_DEF = 1023;

    // calendar constants
    localparam int YEAR_MAX      = 9999;
    localparam int MONTHS        = 12;
    localparam int LEAP_CYCLE    = 400;
    localparam int CENTURY       = 100;
    localparam int DAYS_PER_WEEK = 7;

    // year reduction: subtract LEAP_CYCLE << k for k = REDUCE_TOP down to 0
    localparam int REDUCE_TOP = 4;

    // unit codes
    localparam logic [OP_W-1:0] OP_DAY        = 3'd0;
    localparam logic [OP_W-1:0] OP_WEEK       = 3'd1;
    localparam logic [OP_W-1:0] OP_MONTH      = 3'd2;
    localparam logic [OP_W-1:0] OP_YEAR       = 3'd3;
    localparam logic [OP_W-1:0] OP_DECADE     = 3'd4;
    localparam logic [OP_W-1:0] OP_CENTURY    = 3'd5;
    localparam logic [OP_W-1:0] OP_MILLENNIUM = 3'd6;
    localparam logic [OP_W-1:0] OP_NONE       = 3'd7;

    // month numbers used by the calendar rules
    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    // one calendar date plus its year position in the 400-year cycle
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [M400_W-1:0]  ymod;
    } t_date;

    // days in a month
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        len = DAY_W'(31);
        if (m == MON_FEB) begin
            len = leap ? DAY_W'(29) : DAY_W'(28);
        end else if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) begin
            len = DAY_W'(30);
        end
        return len;
    endfunction

    // years per unit for the year-sized units
    function automatic logic [UNIT_W-1:0] unit_years(input logic [OP_W-1:0] op);
        logic [UNIT_W-1:0] u;
        unique case (op)
            OP_DECADE:     u = UNIT_W'(10);
            OP_CENTURY:    u = UNIT_W'(100);
            OP_MILLENNIUM: u = UNIT_W'(1000);
            default:       u = UNIT_W'(1);
        endcase
        return u;
    endfunction

endpackage

### hw/rtl/gds_cal_step.sv
// ----------------------------------------------------------------------------
// gds_cal_step
// One calendar step back: one day, or one month with the day clamped to the
// new month's length. Flags a step that would leave year 0.
// ----------------------------------------------------------------------------
module gds_cal_step (
    input  gds_pkg::t_date i_cur,
    input  logic           i_month_mode,
    output gds_pkg::t_date o_nxt,
    output logic           o_fail
);
    import gds_pkg::*;

    logic               leap;
    logic               year_wrap;
    logic [MONTH_W-1:0] prev_month;
    logic [DAY_W-1:0]   prev_len;
    logic [M400_W-1:0]  prev_ymod;

    // leap year from the position in the 400-year cycle
    assign leap = (i_cur.ymod == '0) ||
                  ((i_cur.ymod[1:0] == 2'b00) &&
                   (i_cur.ymod != M400_W'(CENTURY)) &&
                   (i_cur.ymod != M400_W'(2*CENTURY)) &&
                   (i_cur.ymod != M400_W'(3*CENTURY)));

    assign year_wrap  = (i_cur.month == MON_JAN);
    assign prev_month = year_wrap ? MON_DEC : i_cur.month - MONTH_W'(1);
    assign prev_len   = month_len(prev_month, leap);
    assign prev_ymod  = (i_cur.ymod == '0) ? M400_W'(LEAP_CYCLE - 1)
                                           : i_cur.ymod - M400_W'(1);

    // next date
    always_comb begin
        o_nxt  = i_cur;
        o_fail = 1'b0;
        if (!i_month_mode && i_cur.day > DAY_W'(1)) begin
            o_nxt.day = i_cur.day - DAY_W'(1);
        end else if (year_wrap && i_cur.year == '0) begin
            o_fail = 1'b1;
        end else begin
            o_nxt.month = prev_month;
            if (year_wrap) begin
                o_nxt.year = i_cur.year - YEAR_W'(1);
                o_nxt.ymod = prev_ymod;
            end
            if (!i_month_mode) begin
                o_nxt.day = prev_len;
            end else if (i_cur.day > prev_len) begin
                o_nxt.day = prev_len;
            end
        end
    end

endmodule

### hw/rtl/gregorian_date_subtract.sv
// ----------------------------------------------------------------------------
// gregorian_date_subtract
// Moves a Gregorian date back by a count of days, weeks, months, years,
// decades, centuries or millennia, saturating at year 0.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------------
//  command  | start / busy     | i_day_in i_month_in i_year_in i_operation
//           |                  | i_count
//  result   | o_strobe (1 clk) | o_day_out o_month_out o_year_out
//           |                  | o_year_underflow
//
//  sequence: load, then year reduction by shifted-divisor subtraction, then
//  day steps (count, or 7 * count for weeks) or month steps (count) through
//  the single calendar step unit; year-sized units instead multiply, then
//  subtract.
//  busy is high from the beat after accept until the result beat.
//  reset is synchronous and active low; it clears the sequencer and strobe.
//  the result beat cannot be stalled; a new command may start on that cycle.
// ----------------------------------------------------------------------------
module gregorian_date_subtract #(
    parameter int MAX_COUNT = gds_pkg::MAX_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [gds_pkg::DAY_W-1:0]   i_day_in,
    input  logic [gds_pkg::MONTH_W-1:0] i_month_in,
    input  logic [gds_pkg::YEAR_W-1:0]  i_year_in,
    input  logic [gds_pkg::OP_W-1:0]    i_operation,
    input  logic [gds_pkg::CNT_W-1:0]   i_count,
    output logic                        o_strobe,
    output logic [gds_pkg::DAY_W-1:0]   o_day_out,
    output logic [gds_pkg::MONTH_W-1:0] o_month_out,
    output logic [gds_pkg::YEAR_W-1:0]  o_year_out,
    output logic                        o_year_underflow
);
    import gds_pkg::*;

    localparam int NW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT + 1) : 1;
    localparam int SW = $clog2(DAYS_PER_WEEK * MAX_COUNT + 1);
    localparam int AW = NW + UNIT_W;
    localparam int PW = $clog2(REDUCE_TOP + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_WALK,
        S_MUL,
        S_SUB
    } t_state;

    t_state             r_state;
    t_date              r_date;
    logic [OP_W-1:0]    r_op;
    logic [NW-1:0]      r_n;
    logic [SW-1:0]      r_steps;
    logic [YEAR_W-1:0]  r_rem;
    logic [PW-1:0]      r_phase;
    logic [AW-1:0]      r_amt;
    logic               r_strobe;
    logic [DAY_W-1:0]   r_day_out;
    logic [MONTH_W-1:0] r_month_out;
    logic [YEAR_W-1:0]  r_year_out;
    logic               r_under_out;

    logic [NW-1:0]      cnt_clamped;
    logic [SW-1:0]      step_total;
    logic [DAY_W-1:0]   day_fix;
    logic [MONTH_W-1:0] month_fix;
    logic [YEAR_W-1:0]  year_fix;
    logic [YEAR_W-1:0]  reduce_div;
    logic               walk_op;
    t_date              step_nxt;
    logic               step_fail;

    // range correction of the command beat
    assign cnt_clamped = (32'(i_count) > 32'(MAX_COUNT)) ? NW'(MAX_COUNT) : NW'(i_count);
    assign step_total  = (i_operation == OP_WEEK)
                       ? (SW'(cnt_clamped) << 3) - SW'(cnt_clamped)
                       : SW'(cnt_clamped);
    assign day_fix     = (i_day_in == '0) ? DAY_W'(1) : i_day_in;
    assign month_fix   = (i_month_in == '0)          ? MON_JAN :
                         (i_month_in > MONTH_W'(MONTHS)) ? MON_DEC : i_month_in;
    assign year_fix    = (i_year_in > YEAR_W'(YEAR_MAX)) ? YEAR_W'(YEAR_MAX) : i_year_in;

    // year mod 400 by shifted-divisor subtraction
    assign reduce_div  = YEAR_W'(LEAP_CYCLE) << r_phase;
    assign walk_op     = (r_op == OP_DAY) || (r_op == OP_WEEK) || (r_op == OP_MONTH);

    // shared calendar step unit
    gds_cal_step u_step (
        .i_cur        (r_date),
        .i_month_mode (r_op == OP_MONTH),
        .o_nxt        (step_nxt),
        .o_fail       (step_fail)
    );

    // sequencer and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_date.day   <= day_fix;
                        r_date.month <= month_fix;
                        r_date.year  <= year_fix;
                        r_date.ymod  <= '0;
                        r_op         <= i_operation;
                        r_n          <= cnt_clamped;
                        r_steps      <= step_total;
                        r_rem        <= year_fix;
                        r_phase      <= PW'(REDUCE_TOP);
                        r_state      <= S_REDUCE;
                    end
                end
                S_REDUCE: begin
                    if (r_rem >= reduce_div) begin
                        r_rem <= r_rem - reduce_div;
                    end
                    if (r_phase == '0) begin
                        r_date.ymod <= (r_rem >= reduce_div)
                                     ? M400_W'(r_rem - reduce_div) : M400_W'(r_rem);
                        if (walk_op && r_steps != '0) begin
                            r_state <= S_WALK;
                        end else if (walk_op || r_op == OP_NONE) begin
                            r_day_out   <= r_date.day;
                            r_month_out <= r_date.month;
                            r_year_out  <= r_date.year;
                            r_under_out <= 1'b0;
                            r_strobe    <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_phase <= r_phase - PW'(1);
                    end
                end
                S_WALK: begin
                    if (step_fail) begin
                        r_day_out   <= DAY_W'(1);
                        r_month_out <= MON_JAN;
                        r_year_out  <= '0;
                        r_under_out <= 1'b1;
                        r_strobe    <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_date  <= step_nxt;
                        r_steps <= r_steps - SW'(1);
                        if (r_steps == SW'(1)) begin
                            r_day_out   <= step_nxt.day;
                            r_month_out <= step_nxt.month;
                            r_year_out  <= step_nxt.year;
                            r_under_out <= 1'b0;
                            r_strobe    <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                S_MUL: begin
                    r_amt   <= AW'(r_n) * AW'(unit_years(r_op));
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_day_out   <= r_date.day;
                    r_month_out <= r_date.month;
                    if (32'(r_amt) > 32'(r_date.year)) begin
                        r_year_out  <= '0;
                        r_under_out <= 1'b1;
                    end else begin
                        r_year_out  <= r_date.year - YEAR_W'(r_amt);
                        r_under_out <= 1'b0;
                    end
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_strobe         = r_strobe;
    assign o_day_out        = r_day_out;
    assign o_month_out      = r_month_out;
    assign o_year_out       = r_year_out;
    assign o_year_underflow = r_under_out;

endmodule

### hw/rtl/gds_checker.sv
// ----------------------------------------------------------------------------
// gds_checker
// Port-level checks on the date subtractor, attached to the top level.
// ----------------------------------------------------------------------------
module gds_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_strobe,
    input logic [gds_pkg::DAY_W-1:0]   o_day_out,
    input logic [gds_pkg::MONTH_W-1:0] o_month_out,
    input logic [gds_pkg::YEAR_W-1:0]  o_year_out,
    input logic                        o_year_underflow
);
    import gds_pkg::*;

    // an accepted beat keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted beat");

    // the result beat closes the command
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while still busy");

    // a result beat lasts one cycle
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result beat longer than one cycle");

    // result date is in range
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_day_out != '0) && (o_month_out != '0) &&
                     (o_month_out <= MONTH_W'(MONTHS)) &&
                     (o_year_out <= YEAR_W'(YEAR_MAX)))
        else $error("result date out of range");

    // underflow saturates the year
    a_under_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_year_underflow) |-> (o_year_out == '0))
        else $error("underflow without year 0");

endmodule

bind gregorian_date_subtract gds_checker u_gds_checker (.*);
